>>> hw/rtl/jsma_pkg.sv
// Shared constants, types and sequencer states for the joint moving-average block.
package jsma_pkg;

  localparam int JOINT_COUNT = 4;
  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int CHANNELS    = 4;

  localparam int JOINT_W = 2;
  localparam int CHAN_W  = $clog2(CHANNELS);
  localparam int LEN_W   = 7;
  localparam int SLOT_W  = $clog2(MAX_WINDOW);
  localparam int SUM_W   = 38;

  localparam logic [LEN_W-1:0]  LEN_RESET = LEN_W'(8);
  localparam logic [CHAN_W-1:0] CHAN_LAST = CHAN_W'(CHANNELS - 1);

  localparam int RING_DEPTH = JOINT_COUNT * MAX_WINDOW;
  localparam int RING_AW    = JOINT_W + SLOT_W;
  localparam int RING_W     = CHANNELS * SAMPLE_BITS;

  // divider retires DIV_RADIX quotient bits per cycle
  localparam int DIV_RADIX = 4;
  localparam int DIV_W     = ((SUM_W + DIV_RADIX - 1) / DIV_RADIX) * DIV_RADIX;
  localparam int DIV_ITER  = DIV_W / DIV_RADIX;
  localparam int DIV_CNT_W = $clog2(DIV_ITER);
  localparam int REM_W     = SLOT_W;
  localparam int CMP_W     = LEN_W + 1;

  typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] sample_vec_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [LEN_W-1:0]        divisor;
  } div_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLACE,
    ST_FETCH,
    ST_ACCUM,
    ST_DIVIDE,
    ST_DELIVER
  } state_t;

endpackage

>>> hw/rtl/jsma_sample_if.sv
// Sample request channel: one joint's four Q16.16 values.
interface jsma_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic [jsma_pkg::JOINT_W-1:0]         joint;
  logic signed [jsma_pkg::SAMPLE_BITS-1:0] position;
  logic signed [jsma_pkg::SAMPLE_BITS-1:0] velocity;
  logic signed [jsma_pkg::SAMPLE_BITS-1:0] acceleration;
  logic signed [jsma_pkg::SAMPLE_BITS-1:0] torque;

  modport source (output valid, joint, position, velocity, acceleration, torque,
                  input ready);
  modport sink (input valid, joint, position, velocity, acceleration, torque,
                output ready);
endinterface

>>> hw/rtl/jsma_avg_if.sv
// Result request channel: one joint's four windowed means and fill count.
interface jsma_avg_if;
  logic                                    valid;
  logic                                    ready;
  logic [jsma_pkg::JOINT_W-1:0]            joint_out;
  logic signed [jsma_pkg::SAMPLE_BITS-1:0] avg_position;
  logic signed [jsma_pkg::SAMPLE_BITS-1:0] avg_velocity;
  logic signed [jsma_pkg::SAMPLE_BITS-1:0] avg_acceleration;
  logic signed [jsma_pkg::SAMPLE_BITS-1:0] avg_torque;
  logic [jsma_pkg::LEN_W-1:0]              fill_count;

  modport source (output valid, joint_out, avg_position, avg_velocity, avg_acceleration,
                  avg_torque, fill_count, input ready);
  modport sink (input valid, joint_out, avg_position, avg_velocity, avg_acceleration,
                avg_torque, fill_count, output ready);
endinterface

>>> hw/rtl/jsma_ram.sv
// Generic single-port RAM with registered read (read-before-write).
module jsma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

>>> hw/rtl/jsma_div.sv
// Iterative signed divider: 38-bit sum by 7-bit count, truncating toward zero.
module jsma_div (
  input  logic                              clk,
  input  logic                              rst,
  input  jsma_pkg::div_req_t                req,
  output logic                              done,
  output logic [jsma_pkg::SAMPLE_BITS-1:0]  quotient
);

  logic                               busy;
  logic [jsma_pkg::DIV_CNT_W-1:0]     cnt;
  logic                               neg;
  logic [jsma_pkg::DIV_W-1:0]         work;
  logic [jsma_pkg::DIV_W-1:0]         work_next;
  logic [jsma_pkg::REM_W-1:0]         rem;
  logic [jsma_pkg::REM_W-1:0]         rem_next;
  logic [jsma_pkg::LEN_W-1:0]         divisor;
  logic [jsma_pkg::SUM_W-1:0]         magnitude;
  logic [jsma_pkg::CMP_W-1:0]         trial;
  logic [jsma_pkg::DIV_W-1:0]         signed_q;

  assign magnitude = req.dividend[jsma_pkg::SUM_W-1] ? jsma_pkg::SUM_W'(-req.dividend)
                                                     : jsma_pkg::SUM_W'(req.dividend);

  // restoring division, DIV_RADIX bits per cycle; quotient bits shift into work
  always_comb begin
    work_next = work;
    rem_next  = rem;
    trial     = '0;
    for (int k = 0; k < jsma_pkg::DIV_RADIX; k++) begin
      trial     = jsma_pkg::CMP_W'({rem_next, work_next[jsma_pkg::DIV_W-1]});
      work_next = {work_next[jsma_pkg::DIV_W-2:0], 1'b0};
      if (trial >= jsma_pkg::CMP_W'(divisor)) begin
        trial        = trial - jsma_pkg::CMP_W'(divisor);
        work_next[0] = 1'b1;
      end
      rem_next = trial[jsma_pkg::REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == jsma_pkg::DIV_CNT_W'(jsma_pkg::DIV_ITER - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg     <= req.dividend[jsma_pkg::SUM_W-1];
      work    <= jsma_pkg::DIV_W'(magnitude);
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign signed_q = neg ? -work : work;
  assign quotient = signed_q[jsma_pkg::SAMPLE_BITS-1:0];

endmodule

>>> hw/rtl/joint_state_moving_average.sv
// Top level: per-joint moving-average filter over four Q16.16 channels.
// Each accepted sample updates its joint's window (ring store of up to 64 samples per joint,
// four 38-bit running sums) and yields one result: the four sums divided by the joint's fill
// count, truncated toward zero, plus that count. One sample is processed at a time; the input
// is ready only while the sequencer idles. Per sample the sequencer runs PLACE (place the slot)
// and FETCH (read/write the ring), then per channel ACCUM (accumulate) and DIVIDE in the single
// shared divider, which retires four quotient bits per cycle over ten iterations. The result
// sits in an output register, so the next sample is taken while it waits; a new result stalls
// only if the previous one has not been taken. Writing the window length (cfg_wr_data; 0 acts as
// 1, above 64 acts as 64) clears all windows at once; write it only while the block is idle.
module joint_state_moving_average (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [jsma_pkg::LEN_W-1:0]   cfg_wr_data,
  jsma_sample_if.sink                  samples,
  jsma_avg_if.source                   averages
);

  jsma_pkg::state_t state, state_next;

  logic [jsma_pkg::LEN_W-1:0]        len_q;
  logic [jsma_pkg::LEN_W-1:0]        eff_len;
  logic [jsma_pkg::LEN_W-1:0]        fill   [jsma_pkg::JOINT_COUNT];
  logic [jsma_pkg::SLOT_W-1:0]       oldest [jsma_pkg::JOINT_COUNT];
  logic signed [jsma_pkg::SUM_W-1:0] sums   [jsma_pkg::JOINT_COUNT][jsma_pkg::CHANNELS];

  logic [jsma_pkg::JOINT_W-1:0]      joint_q;
  jsma_pkg::sample_vec_t             samp_q;
  logic [jsma_pkg::SLOT_W-1:0]       slot_q;
  logic                              full_q;
  logic [jsma_pkg::CHAN_W-1:0]       chan;
  logic [jsma_pkg::SAMPLE_BITS-1:0]  avg_q [jsma_pkg::CHANNELS];

  logic                              out_valid;
  logic [jsma_pkg::JOINT_W-1:0]      out_joint;
  logic [jsma_pkg::LEN_W-1:0]        out_fill;
  logic [jsma_pkg::SAMPLE_BITS-1:0]  out_avg [jsma_pkg::CHANNELS];

  // control decoded from state
  logic accept;
  logic ram_en;
  logic load_out;
  logic div_start;

  // slot placement
  logic [jsma_pkg::LEN_W-1:0]        cur_fill;
  logic [jsma_pkg::SLOT_W-1:0]       cur_oldest;
  logic [jsma_pkg::LEN_W:0]          grow_slot;
  logic [jsma_pkg::SLOT_W-1:0]       wrap_slot;
  logic [jsma_pkg::LEN_W-1:0]        wrap_inc;
  logic [jsma_pkg::SLOT_W-1:0]       slot_next;
  logic [jsma_pkg::SLOT_W-1:0]       oldest_next;
  logic [jsma_pkg::LEN_W-1:0]        fill_next;
  logic                              full_next;

  jsma_pkg::sample_vec_t             ring_rdata;
  logic signed [jsma_pkg::SUM_W-1:0] sum_rd;
  logic signed [jsma_pkg::SUM_W-1:0] old_ext;
  logic signed [jsma_pkg::SUM_W-1:0] new_ext;
  logic signed [jsma_pkg::SUM_W-1:0] sum_next;

  jsma_pkg::div_req_t                div_req;
  logic                              div_done;
  logic [jsma_pkg::SAMPLE_BITS-1:0]  div_quot;

  always_comb begin
    if (len_q == '0) begin
      eff_len = jsma_pkg::LEN_W'(1);
    end else if (len_q > jsma_pkg::LEN_W'(jsma_pkg::MAX_WINDOW)) begin
      eff_len = jsma_pkg::LEN_W'(jsma_pkg::MAX_WINDOW);
    end else begin
      eff_len = len_q;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      jsma_pkg::ST_IDLE: begin
        if (samples.valid) state_next = jsma_pkg::ST_PLACE;
      end
      jsma_pkg::ST_PLACE:  state_next = jsma_pkg::ST_FETCH;
      jsma_pkg::ST_FETCH:  state_next = jsma_pkg::ST_ACCUM;
      jsma_pkg::ST_ACCUM:  state_next = jsma_pkg::ST_DIVIDE;
      jsma_pkg::ST_DIVIDE: begin
        if (div_done) begin
          state_next = (chan == jsma_pkg::CHAN_LAST) ? jsma_pkg::ST_DELIVER
                                                     : jsma_pkg::ST_ACCUM;
        end
      end
      jsma_pkg::ST_DELIVER: begin
        if (!out_valid || averages.ready) state_next = jsma_pkg::ST_IDLE;
      end
      default: state_next = jsma_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    samples.ready = 1'b0;
    ram_en        = 1'b0;
    div_start     = 1'b0;
    load_out      = 1'b0;
    unique case (state)
      jsma_pkg::ST_IDLE:    samples.ready = 1'b1;
      jsma_pkg::ST_FETCH:   ram_en = 1'b1;
      jsma_pkg::ST_ACCUM:   div_start = 1'b1;
      jsma_pkg::ST_DELIVER: load_out = !out_valid || averages.ready;
      default: ;
    endcase
  end

  assign accept = samples.valid && samples.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jsma_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ring slot for this sample: append while filling, else overwrite the oldest
  always_comb begin
    cur_fill    = fill[joint_q];
    cur_oldest  = oldest[joint_q];
    grow_slot   = (jsma_pkg::LEN_W + 1)'(cur_oldest) + (jsma_pkg::LEN_W + 1)'(cur_fill);
    wrap_slot   = (jsma_pkg::LEN_W'(cur_oldest) >= eff_len) ? '0 : cur_oldest;
    wrap_inc    = jsma_pkg::LEN_W'(wrap_slot) + 1'b1;
    slot_next   = wrap_slot;
    oldest_next = cur_oldest;
    fill_next   = eff_len;
    full_next   = 1'b1;
    if (cur_fill < eff_len) begin
      if (grow_slot >= (jsma_pkg::LEN_W + 1)'(eff_len)) begin
        grow_slot = grow_slot - (jsma_pkg::LEN_W + 1)'(eff_len);
      end
      slot_next = grow_slot[jsma_pkg::SLOT_W-1:0];
      fill_next = cur_fill + 1'b1;
      full_next = 1'b0;
    end else begin
      oldest_next = (wrap_inc >= eff_len) ? '0 : wrap_inc[jsma_pkg::SLOT_W-1:0];
    end
  end

  jsma_ram #(
    .WIDTH (jsma_pkg::RING_W),
    .DEPTH (jsma_pkg::RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_en),
    .addr  ({joint_q, slot_q}),
    .wdata (samp_q),
    .rdata (ring_rdata)
  );

  // accumulate: drop the evicted sample (if any) and add the new one
  assign sum_rd   = sums[joint_q][chan];
  assign old_ext  = full_q ? jsma_pkg::SUM_W'($signed(ring_rdata[chan])) : '0;
  assign new_ext  = jsma_pkg::SUM_W'($signed(samp_q[chan]));
  assign sum_next = sum_rd - old_ext + new_ext;

  assign div_req = '{start: div_start, dividend: sum_next, divisor: fill[joint_q]};

  jsma_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quot)
  );

  // window state: cleared on reset and on every length write
  always_ff @(posedge clk) begin
    if (rst || cfg_wr_en) begin
      for (int j = 0; j < jsma_pkg::JOINT_COUNT; j++) begin
        fill[j]   <= '0;
        oldest[j] <= '0;
        for (int c = 0; c < jsma_pkg::CHANNELS; c++) begin
          sums[j][c] <= '0;
        end
      end
    end else begin
      if (state == jsma_pkg::ST_PLACE) begin
        fill[joint_q]   <= fill_next;
        oldest[joint_q] <= oldest_next;
      end
      if (state == jsma_pkg::ST_ACCUM) begin
        sums[joint_q][chan] <= sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_q <= jsma_pkg::LEN_RESET;
    end else if (cfg_wr_en) begin
      len_q <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan <= '0;
    end else if (accept) begin
      chan <= '0;
    end else if (state == jsma_pkg::ST_DIVIDE && div_done) begin
      chan <= chan + 1'b1;
    end
  end

  // per-item payload
  always_ff @(posedge clk) begin
    if (accept) begin
      joint_q   <= samples.joint;
      samp_q[0] <= samples.position;
      samp_q[1] <= samples.velocity;
      samp_q[2] <= samples.acceleration;
      samp_q[3] <= samples.torque;
    end
    if (state == jsma_pkg::ST_PLACE) begin
      slot_q <= slot_next;
      full_q <= full_next;
    end
    if (state == jsma_pkg::ST_DIVIDE && div_done) begin
      avg_q[chan] <= div_quot;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (averages.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_joint <= joint_q;
      out_fill  <= fill[joint_q];
      out_avg   <= avg_q;
    end
  end

  assign averages.valid            = out_valid;
  assign averages.joint_out        = out_joint;
  assign averages.avg_position     = out_avg[0];
  assign averages.avg_velocity     = out_avg[1];
  assign averages.avg_acceleration = out_avg[2];
  assign averages.avg_torque       = out_avg[3];
  assign averages.fill_count       = out_fill;

endmodule

>>> sim/joint_state_moving_average_tb.sv
// Testbench for joint_state_moving_average: self-checking, with a per-joint window predictor.
`timescale 1ns / 1ps

module joint_state_moving_average_tb;
  import jsma_pkg::*;

  localparam int CH_POS = 0;
  localparam int CH_VEL = 1;
  localparam int CH_ACC = 2;
  localparam int CH_TOR = 3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 700;

  typedef enum int {PACE_FULL, PACE_SRC_IDLE, PACE_SINK_STALL, PACE_BOTH} pace_t;

  typedef struct {
    logic [JOINT_W-1:0]                   joint;
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0] chan;
  } sample_t;

  typedef struct {
    logic [JOINT_W-1:0]                   joint;
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0] chan;
    logic [LEN_W-1:0]                     fill;
  } avg_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [LEN_W-1:0] cfg_wr_data;

  jsma_sample_if samples();
  jsma_avg_if    averages();

  joint_state_moving_average DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .samples     (samples),
    .averages    (averages)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [LEN_W-1:0]        win_len;
  logic signed [SAMPLE_BITS-1:0] ring_mem [JOINT_COUNT][MAX_WINDOW][CHANNELS];
  logic signed [SUM_W-1:0] sum_acc [JOINT_COUNT][CHANNELS];
  int unsigned             fill_cnt [JOINT_COUNT];
  int unsigned             oldest [JOINT_COUNT];

  sample_t pending_samples[$];
  avg_t    expected_avgs[$];
  sample_t in_flight;
  pace_t   pace = PACE_FULL;
  int      mismatches = 0;
  int      cycles = 0;
  logic    hold_go;
  int      hold_left = 0;

  function automatic void clear_windows();
    for (int j = 0; j < JOINT_COUNT; j++) begin
      fill_cnt[j] = 0;
      oldest[j] = 0;
      for (int c = 0; c < CHANNELS; c++) sum_acc[j][c] = '0;
    end
  endfunction

  function automatic avg_t window_average(sample_t s);
    avg_t r;
    int unsigned len, slot, j;
    longint q;
    len = (win_len == 0) ? 1 : (win_len > MAX_WINDOW) ? MAX_WINDOW : win_len;
    j = s.joint;
    if (fill_cnt[j] < len) begin
      slot = oldest[j] + fill_cnt[j];
      if (slot >= len) slot -= len;
      fill_cnt[j]++;
    end else begin
      // window full: retire the oldest sample
      slot = (oldest[j] >= len) ? 0 : oldest[j];
      for (int c = 0; c < CHANNELS; c++) sum_acc[j][c] -= ring_mem[j][slot][c];
      oldest[j] = (slot + 1 >= len) ? 0 : slot + 1;
      fill_cnt[j] = len;
    end
    r.joint = s.joint;
    for (int c = 0; c < CHANNELS; c++) begin
      ring_mem[j][slot][c] = s.chan[c];
      sum_acc[j][c] += ring_mem[j][slot][c];
      q = longint'(sum_acc[j][c]) / longint'(fill_cnt[j]);
      r.chan[c] = q[SAMPLE_BITS-1:0];
    end
    r.fill = LEN_W'(fill_cnt[j]);
    return r;
  endfunction

  function automatic bit rest_now(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      samples.valid <= 1'b0;
    end else begin
      if (samples.valid && samples.ready)
        expected_avgs.insert(expected_avgs.size(), window_average(in_flight));
      if (!samples.valid || samples.ready) begin
        if (pending_samples.size() != 0 &&
            !rest_now(pace == PACE_SRC_IDLE ? 86 : pace == PACE_BOTH ? 32 : 0)) begin
          in_flight = pending_samples.pop_front();
          samples.joint        <= in_flight.joint;
          samples.position     <= in_flight.chan[CH_POS];
          samples.velocity     <= in_flight.chan[CH_VEL];
          samples.acceleration <= in_flight.chan[CH_ACC];
          samples.torque       <= in_flight.chan[CH_TOR];
          samples.valid        <= 1'b1;
        end else begin
          samples.valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    avg_t want;
    if (rst) begin
      averages.ready <= 1'b0;
    end else begin
      if (averages.valid && averages.ready) begin
        if (expected_avgs.size() == 0) begin
          mismatches++;
          $display("%0t: result for joint %0d with no request pending", $time,
                   averages.joint_out);
        end else begin
          want = expected_avgs.pop_front();
          check_field("joint_out", want.joint, averages.joint_out);
          check_field("avg_position", $signed(want.chan[CH_POS]), averages.avg_position);
          check_field("avg_velocity", $signed(want.chan[CH_VEL]), averages.avg_velocity);
          check_field("avg_acceleration", $signed(want.chan[CH_ACC]),
                      averages.avg_acceleration);
          check_field("avg_torque", $signed(want.chan[CH_TOR]), averages.avg_torque);
          check_field("fill_count", want.fill, averages.fill_count);
        end
      end
      averages.ready <= (hold_left == 0) &&
                        !rest_now(pace == PACE_SINK_STALL ? 86 : pace == PACE_BOTH ? 32 : 0);
    end
  end

  // long output hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (hold_go) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [SAMPLE_BITS-1:0] rand_word();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($urandom_range(511)) - 32'd256;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_sample(int j, logic [31:0] p, logic [31:0] v, logic [31:0] a,
                              logic [31:0] t);
    sample_t s;
    s.joint = JOINT_W'(j);
    s.chan[CH_POS] = p;
    s.chan[CH_VEL] = v;
    s.chan[CH_ACC] = a;
    s.chan[CH_TOR] = t;
    pending_samples.insert(pending_samples.size(), s);
  endtask

  task automatic queue_random(int count);
    sample_t s;
    int unsigned next_joint;
    next_joint = $urandom_range(JOINT_COUNT - 1);
    repeat (count) begin
      // mostly joints in rotation, as a control loop sends them
      if ($urandom_range(99) < 80) begin
        s.joint = JOINT_W'(next_joint);
        next_joint = (next_joint + 1) % JOINT_COUNT;
      end else begin
        s.joint = JOINT_W'($urandom_range(JOINT_COUNT - 1));
      end
      for (int c = 0; c < CHANNELS; c++) s.chan[c] = rand_word();
      pending_samples.insert(pending_samples.size(), s);
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_samples.size() != 0 || samples.valid || expected_avgs.size() != 0);
  endtask

  task automatic write_window(logic [LEN_W-1:0] len);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    win_len = len;
    clear_windows();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int phase_len [8]   = '{64, 1, 127, 5, 65, 0, 8, 2};
    int phase_items [8] = '{320, 100, 300, 120, 300, 80, 130, 100};
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    hold_go = 1'b0;
    win_len = LEN_RESET;
    clear_windows();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset length: joint 0 wraps its window with extreme values
    for (int i = 0; i < 10; i++)
      queue_sample(0, (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000, 32'h8000_0000,
                   32'h7FFF_FFFF, (i < 5) ? 32'hFFFF_FFFF : 32'h0000_0000);
    // truncation toward zero on negative sums
    queue_sample(1, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFD, 32'h0000_0003);
    queue_sample(1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    queue_sample(2, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000, 32'h0000_FFFF);
    queue_sample(3, 32'h0001_0000, 32'hFFFF_8000, 32'h0000_0001, 32'h8000_0001);
    wait_idle();

    write_window(7'd1);
    queue_sample(3, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_sample(3, 32'h1234_5678, 32'hFEDC_BA98, 32'h0000_0001, 32'h8000_0000);
    queue_sample(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    wait_idle();

    // zero acts as a window of one
    write_window(7'd0);
    queue_sample(2, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0005);
    queue_sample(2, 32'h0000_0003, 32'hFFFF_FFFB, 32'h7FFF_FFFF, 32'h8000_0000);
    wait_idle();

    for (int i = 0; i < 8; i++) begin
      write_window(i == 7 ? LEN_W'($urandom_range(2, MAX_WINDOW - 1)) : LEN_W'(phase_len[i]));
      pace = pace_t'(i % 4);
      queue_random(phase_items[i]);
      if (i == 0) begin
        repeat (30) @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      wait_idle();
    end

    pace = PACE_FULL;
    repeat (120) @(posedge clk);
    if (mismatches == 0 && expected_avgs.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/jsma_pkg.sv
hw/rtl/jsma_sample_if.sv
hw/rtl/jsma_avg_if.sv
hw/rtl/jsma_ram.sv
hw/rtl/jsma_div.sv
hw/rtl/joint_state_moving_average.sv
sim/joint_state_moving_average_tb.sv
